@@ rtl/core/mtl_pkg.sv @@
package mtl_pkg;

    // Scanner states. The end-marker states run as one contiguous block of codes.
    typedef enum logic [4:0] {
        S_START = 5'd0,
        S_CMT   = 5'd1,
        S_EOF01 = 5'd2,
        S_EOF02 = 5'd3,
        S_EOF03 = 5'd4,
        S_EOF04 = 5'd5,
        S_EOF05 = 5'd6,
        S_EOF06 = 5'd7,
        S_EOF07 = 5'd8,
        S_EOF08 = 5'd9,
        S_EOF09 = 5'd10,
        S_EOF10 = 5'd11,
        S_ETQ   = 5'd12,
        S_NUM01 = 5'd13,
        S_NUM02 = 5'd14,
        S_SPC   = 5'd15,
        S_STR   = 5'd16,
        S_S01   = 5'd17,
        S_S02   = 5'd18,
        S_S03   = 5'd19
    } scan_state_t;

    typedef enum logic [2:0] {
        K_LABEL  = 3'd0,
        K_OPEN   = 3'd1,
        K_CLOSE  = 3'd2,
        K_INT    = 3'd3,
        K_REAL   = 3'd4,
        K_STRING = 3'd5,
        K_EOF    = 3'd6,
        K_ERROR  = 3'd7
    } token_kind_t;

    typedef struct packed {
        token_kind_t kind;
        logic [7:0]  start_col;
        logic [8:0]  token_length;
        logic        last_of_run;
    } token_t;

    localparam logic [7:0] CH_EOF = 8'h03;
    localparam logic [7:0] CH_EOL = 8'h04;
    localparam logic [7:0] CH_TAB = 8'h09;

    // Wide enough for any column or length under the supported line sizes.
    localparam int          SAT_W         = 16;
    localparam logic [15:0] START_COL_MAX = 16'd255;
    localparam logic [15:0] LENGTH_MAX    = 16'd511;
    localparam int          MARKER_LEN    = 11;

    localparam int         FIFO_DEPTH = 4;
    localparam int         FIFO_PTR_W = 2;
    localparam int         FIFO_CNT_W = 3;
    // A step may push two results, so it needs two free entries.
    localparam logic [2:0] STEP_ROOM  = 3'd2;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
               c == 8'hD1 || c == 8'hF1;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic label_cont(input logic [7:0] c);
        return is_letter(c) || is_digit(c) || c == "_" || c == "." || c == "+" ||
               c == "-" || c == "#" || c == "/" || c == "=" || c == "'" ||
               c == "]" || c == "|" || c == ":";
    endfunction

    // Character expected in each end-marker state but S_EOF10, whose '>' the scanner checks itself.
    function automatic logic [7:0] marker_char(input scan_state_t st);
        logic [7:0] ch;
        case (st)
            S_EOF01: ch = "<";
            S_EOF02: ch = "$";
            S_EOF03: ch = "$";
            S_EOF04: ch = "E";
            S_EOF05: ch = "O";
            S_EOF06: ch = "F";
            S_EOF07: ch = "$";
            S_EOF08: ch = "$";
            S_EOF09: ch = ">";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

@@ rtl/core/mtl_scan.sv @@
module mtl_scan #(
    parameter int LINE_MAX = 256
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       char_code,
    output mtl_pkg::token_t  res0,
    output mtl_pkg::token_t  res1,
    output logic [1:0]       res_vld
);

    localparam int COL_W = $clog2(LINE_MAX + 1);
    localparam logic [COL_W-1:0] COL_MAX = COL_W'(LINE_MAX);

    mtl_pkg::scan_state_t state_reg, state_next;
    logic [COL_W-1:0]     column_reg, column_next;
    logic [COL_W-1:0]     tstart_reg, tstart_next;
    logic                 abbr_reg, abbr_next;
    logic                 skip_reg, skip_next;

    logic [7:0]           c;
    logic [COL_W-1:0]     span;
    logic [COL_W:0]       spanx, span_p1, tsx, colx;
    logic                 line_end;

    // Outcome of starting a fresh token with the current character.
    mtl_pkg::scan_state_t sc_state;
    logic                 sc_vld;
    mtl_pkg::token_kind_t sc_kind;
    logic                 sc_len;
    logic                 sc_line_end;
    logic                 sc_abbr_clr;

    logic                 use_sc;
    logic                 do_fail;
    logic [1:0]           e_vld;
    mtl_pkg::token_kind_t e_kind [2];
    logic [COL_W:0]       e_start [2];
    logic [COL_W:0]       e_len [2];
    logic [mtl_pkg::SAT_W-1:0] s_wide [2];
    logic [mtl_pkg::SAT_W-1:0] l_wide [2];
    mtl_pkg::token_t      tok [2];

    assign c       = (char_code == mtl_pkg::CH_TAB) ? " " : char_code;
    assign span    = (column_reg >= tstart_reg) ? column_reg - tstart_reg : '0;
    assign spanx   = {1'b0, span};
    assign span_p1 = spanx + 1'b1;
    assign tsx     = {1'b0, tstart_reg};
    assign colx    = {1'b0, column_reg};

    always_comb
    begin
        sc_state    = mtl_pkg::S_START;
        sc_vld      = 1'b0;
        sc_kind     = mtl_pkg::K_ERROR;
        sc_len      = 1'b1;
        sc_line_end = 1'b0;
        sc_abbr_clr = 1'b0;
        if (mtl_pkg::is_letter(c) || c == "'" || c == "[" || c == "|" || c == ":") begin
            sc_state = mtl_pkg::S_ETQ;
        end else if (mtl_pkg::is_digit(c)) begin
            sc_state = mtl_pkg::S_NUM01;
        end else if (c == "(") begin
            sc_vld  = 1'b1;
            sc_kind = mtl_pkg::K_OPEN;
        end else if (c == ")") begin
            sc_vld  = 1'b1;
            sc_kind = mtl_pkg::K_CLOSE;
        end else if (c == " ") begin
            if (abbr_reg) begin
                sc_abbr_clr = 1'b1;
                sc_vld      = 1'b1;
                sc_kind     = mtl_pkg::K_CLOSE;
                sc_len      = 1'b0;
            end else begin
                sc_state = mtl_pkg::S_SPC;
            end
        end else if (c == "/") begin
            sc_state = mtl_pkg::S_CMT;
        end else if (c == "+" || c == "-") begin
            sc_state = mtl_pkg::S_S01;
        end else if (c == "=") begin
            sc_state = mtl_pkg::S_S02;
        end else if (c == "\"") begin
            sc_state = mtl_pkg::S_STR;
        end else if (c == mtl_pkg::CH_EOF) begin
            sc_vld  = 1'b1;
            sc_kind = mtl_pkg::K_EOF;
            sc_len  = 1'b0;
        end else if (c == mtl_pkg::CH_EOL) begin
            sc_line_end = 1'b1;
        end else if (c == "<") begin
            sc_state = mtl_pkg::S_EOF01;
        end else if (c == ",") begin
            sc_vld = !abbr_reg;
        end else begin
            sc_vld = 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        tstart_next = tstart_reg;
        abbr_next  = abbr_reg;
        skip_next  = skip_reg;
        line_end   = 1'b0;
        use_sc     = 1'b0;
        do_fail    = 1'b0;
        e_vld      = 2'b00;
        for (int i = 0; i < 2; i++) begin
            e_kind[i]  = mtl_pkg::K_LABEL;
            e_start[i] = tsx;
            e_len[i]   = spanx;
        end

        if (skip_reg) begin
            if (c == mtl_pkg::CH_EOL) begin
                skip_next = 1'b0;
                line_end  = 1'b1;
            end
        end else begin
            case (state_reg)
                mtl_pkg::S_START:
                begin
                    use_sc = 1'b1;
                end
                mtl_pkg::S_CMT:
                begin
                    if (c == "/") begin
                        skip_next  = 1'b1;
                        state_next = mtl_pkg::S_START;
                    end else begin
                        do_fail = 1'b1;
                    end
                end
                mtl_pkg::S_EOF01, mtl_pkg::S_EOF02, mtl_pkg::S_EOF03,
                mtl_pkg::S_EOF04, mtl_pkg::S_EOF05, mtl_pkg::S_EOF06,
                mtl_pkg::S_EOF07, mtl_pkg::S_EOF08, mtl_pkg::S_EOF09:
                begin
                    if (c == mtl_pkg::marker_char(state_reg)) begin
                        state_next = mtl_pkg::scan_state_t'(state_reg + 5'd1);
                    end else begin
                        do_fail = 1'b1;
                    end
                end
                mtl_pkg::S_EOF10:
                begin
                    if (c == ">") begin
                        e_vld[0]   = 1'b1;
                        e_kind[0]  = mtl_pkg::K_EOF;
                        e_len[0]   = (COL_W+1)'(mtl_pkg::MARKER_LEN);
                        skip_next  = 1'b1;
                        state_next = mtl_pkg::S_START;
                    end else begin
                        do_fail = 1'b1;
                    end
                end
                mtl_pkg::S_ETQ:
                begin
                    if (mtl_pkg::label_cont(c)) begin
                        state_next = mtl_pkg::S_ETQ;
                    end else if (c == ",") begin
                        // The first label comma opens an implicit group.
                        if (!abbr_reg) begin
                            abbr_next = 1'b1;
                            e_vld     = 2'b11;
                            e_kind[0] = mtl_pkg::K_OPEN;
                            e_len[0]  = '0;
                            e_kind[1] = mtl_pkg::K_LABEL;
                        end else begin
                            e_vld[0] = 1'b1;
                        end
                        state_next = mtl_pkg::S_START;
                    end else begin
                        e_vld[0] = 1'b1;
                        use_sc   = 1'b1;
                    end
                end
                mtl_pkg::S_NUM01:
                begin
                    if (mtl_pkg::is_digit(c)) begin
                        state_next = mtl_pkg::S_NUM01;
                    end else if (c == ".") begin
                        state_next = mtl_pkg::S_NUM02;
                    end else if (mtl_pkg::is_letter(c)) begin
                        state_next = mtl_pkg::S_ETQ;
                    end else begin
                        e_vld[0]  = 1'b1;
                        e_kind[0] = mtl_pkg::K_INT;
                        use_sc    = 1'b1;
                    end
                end
                mtl_pkg::S_NUM02:
                begin
                    if (!mtl_pkg::is_digit(c)) begin
                        e_vld[0]  = 1'b1;
                        e_kind[0] = mtl_pkg::K_REAL;
                        use_sc    = 1'b1;
                    end
                end
                mtl_pkg::S_SPC:
                begin
                    if (c != " ") begin
                        use_sc = 1'b1;
                    end
                end
                mtl_pkg::S_STR:
                begin
                    if (c == "\"") begin
                        e_vld[0]   = 1'b1;
                        e_kind[0]  = mtl_pkg::K_STRING;
                        e_start[0] = tsx + 1'b1;
                        e_len[0]   = (span != '0) ? spanx - 1'b1 : '0;
                        state_next = mtl_pkg::S_START;
                    end else if (c == mtl_pkg::CH_EOF || c == mtl_pkg::CH_EOL) begin
                        do_fail = 1'b1;
                    end
                end
                mtl_pkg::S_S01, mtl_pkg::S_S02, mtl_pkg::S_S03:
                begin
                    if (mtl_pkg::is_letter(c)) begin
                        state_next = mtl_pkg::S_ETQ;
                    end else if (mtl_pkg::is_digit(c)) begin
                        state_next = mtl_pkg::S_NUM01;
                    end else if (state_reg != mtl_pkg::S_S03 && (c == "+" || c == "-")) begin
                        state_next = mtl_pkg::S_S03;
                    end else if (state_reg == mtl_pkg::S_S01 && c == " ") begin
                        // A lone sign followed by a space is a label.
                        e_vld[0]   = 1'b1;
                        state_next = mtl_pkg::S_START;
                    end else begin
                        do_fail = 1'b1;
                    end
                end
                default:
                begin
                    use_sc = 1'b1;
                end
            endcase
        end

        if (do_fail) begin
            state_next = mtl_pkg::S_START;
            e_vld[0]   = 1'b1;
            if (c == mtl_pkg::CH_EOF) begin
                e_kind[0] = mtl_pkg::K_EOF;
                e_len[0]  = '0;
            end else begin
                e_kind[0] = mtl_pkg::K_ERROR;
                e_len[0]  = span_p1;
                line_end  = (c == mtl_pkg::CH_EOL);
            end
        end

        if (use_sc) begin
            state_next  = sc_state;
            tstart_next = column_reg;
            if (sc_abbr_clr) begin
                abbr_next = 1'b0;
            end
            line_end = line_end | sc_line_end;
            if (sc_vld) begin
                if (e_vld[0]) begin
                    e_vld[1]   = 1'b1;
                    e_kind[1]  = sc_kind;
                    e_start[1] = colx;
                    e_len[1]   = (COL_W+1)'(sc_len);
                end else begin
                    e_vld[0]   = 1'b1;
                    e_kind[0]  = sc_kind;
                    e_start[0] = colx;
                    e_len[0]   = (COL_W+1)'(sc_len);
                end
            end
        end
    end

    always_comb
    begin
        if (line_end) begin
            column_next = '0;
        end else if (column_reg < COL_MAX) begin
            column_next = column_reg + 1'b1;
        end else begin
            column_next = COL_MAX;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 2; i++) begin
            s_wide[i] = mtl_pkg::SAT_W'(e_start[i]);
            l_wide[i] = mtl_pkg::SAT_W'(e_len[i]);
            tok[i].kind = e_kind[i];
            tok[i].start_col = (s_wide[i] > mtl_pkg::START_COL_MAX) ?
                               8'hFF : s_wide[i][7:0];
            tok[i].token_length = (l_wide[i] > mtl_pkg::LENGTH_MAX) ?
                                  9'h1FF : l_wide[i][8:0];
        end
        tok[0].last_of_run = !e_vld[1];
        tok[1].last_of_run = 1'b1;
    end

    assign res0    = tok[0];
    assign res1    = tok[1];
    assign res_vld = e_vld;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg  <= mtl_pkg::S_START;
            column_reg <= '0;
            tstart_reg <= '0;
            abbr_reg   <= 1'b0;
            skip_reg   <= 1'b0;
        end else if (step) begin
            state_reg  <= state_next;
            column_reg <= column_next;
            tstart_reg <= tstart_next;
            abbr_reg   <= abbr_next;
            skip_reg   <= skip_next;
        end
    end

endmodule

@@ rtl/core/mtl_fifo.sv @@
module mtl_fifo (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [1:0]                     push_vld,
    input  mtl_pkg::token_t                push0,
    input  mtl_pkg::token_t                push1,
    input  logic                           pop,
    output mtl_pkg::token_t                head,
    output logic [mtl_pkg::FIFO_CNT_W-1:0] count
);

    mtl_pkg::token_t                 entry_reg [mtl_pkg::FIFO_DEPTH];
    logic [mtl_pkg::FIFO_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [mtl_pkg::FIFO_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [mtl_pkg::FIFO_CNT_W-1:0]  count_reg, count_next;
    logic [mtl_pkg::FIFO_CNT_W-1:0]  n_push;

    // Pushes always fill slot 0 first, so the count is the sum of the bits.
    assign n_push = mtl_pkg::FIFO_CNT_W'(push_vld[0]) + mtl_pkg::FIFO_CNT_W'(push_vld[1]);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + mtl_pkg::FIFO_PTR_W'(n_push);
        rd_ptr_next = rd_ptr_reg + mtl_pkg::FIFO_PTR_W'(pop);
        count_next  = count_reg + n_push - mtl_pkg::FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_vld[0]) begin
            entry_reg[wr_ptr_reg] <= push0;
        end
        if (push_vld[1]) begin
            entry_reg[wr_ptr_reg + 1'b1] <= push1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head  = entry_reg[rd_ptr_reg];
    assign count = count_reg;

endmodule

@@ rtl/core/markup_token_lexer.sv @@
// Character-serial lexer for a parenthesized score language.
// Input channel: one byte per transfer on char_code, handshaked by in_valid and
// in_ready. Byte 4 ends a line, byte 3 ends the file and a tab counts as a space.
// Output channel: one token descriptor per transfer (token_kind, start_col,
// token_length, last_of_run), handshaked by out_valid and out_ready. A byte
// causes zero, one or two descriptors; last_of_run marks the last one of a byte.
// A taken byte waits in the input register until the queue has room; the scan
// step then writes its descriptors into the result queue, whose head is
// offered on the output channel.
// Throughput: one byte per cycle while the queue has room, set by the scan step
// between the input register and a four-entry result queue. A byte is scanned
// only while the queue holds at most two descriptors, so when the receiver stalls
// the queue fills, scanning halts and in_ready drops once the input register is
// full. Bursts of two-descriptor bytes run at the output rate of one per cycle.
// Reset clears the scanner to its start state with column zero, and empties
// both the input register and the result queue.
module markup_token_lexer #(
    parameter int LINE_MAX = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_code,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] token_kind,
    output logic [7:0] start_col,
    output logic [8:0] token_length,
    output logic       last_of_run
);

    logic [7:0]                     char_reg;
    logic                           in_vld_reg;
    logic                           step;
    logic                           pop;
    logic [1:0]                     res_vld;
    logic [1:0]                     push_vld;
    mtl_pkg::token_t                res0;
    mtl_pkg::token_t                res1;
    mtl_pkg::token_t                head;
    logic [mtl_pkg::FIFO_CNT_W-1:0] count;

    // Scan the held byte only when the queue has room for two descriptors.
    // This depends on registered state only, so out_ready never reaches in_ready.
    assign step     = in_vld_reg && (count <= mtl_pkg::STEP_ROOM);
    assign in_ready = !in_vld_reg || step;
    assign push_vld = step ? res_vld : 2'b00;
    assign pop      = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_vld_reg <= 1'b0;
        end else if (in_valid && in_ready) begin
            in_vld_reg <= 1'b1;
        end else if (step) begin
            in_vld_reg <= 1'b0;
        end
    end

    // The byte itself needs no reset; it is qualified by in_vld_reg.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            char_reg <= char_code;
        end
    end

    mtl_scan #(
        .LINE_MAX (LINE_MAX)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .char_code (char_reg),
        .res0      (res0),
        .res1      (res1),
        .res_vld   (res_vld)
    );

    mtl_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_vld (push_vld),
        .push0    (res0),
        .push1    (res1),
        .pop      (pop),
        .head     (head),
        .count    (count)
    );

    assign out_valid    = (count != '0);
    assign token_kind   = head.kind;
    assign start_col    = head.start_col;
    assign token_length = head.token_length;
    assign last_of_run  = head.last_of_run;

`ifndef SYNTH
    // The second descriptor slot is used only after the first one is filled.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(res_vld[1] && !res_vld[0]))
        else $error("second result without a first result");

    // The queue never holds more descriptors than it has entries.
    assert property (@(posedge clk) disable iff (!rst_n)
        count <= mtl_pkg::FIFO_CNT_W'(mtl_pkg::FIFO_DEPTH))
        else $error("result queue overflow");

    // A scan step that produces a descriptor makes the output valid next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && (res_vld != 2'b00)) |=> out_valid)
        else $error("scanned descriptor not offered");

    // Backpressure on the input only comes from a full input register while the queue holds more than two descriptors.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (in_vld_reg && (count > mtl_pkg::STEP_ROOM)))
        else $error("input stalled without cause");
`endif

endmodule

@@ test/tb.sv @@
module tb;

    // The line size matches the default of the block. The column counter of the
    // prediction saturates at this value, just like the hardware counter.
    localparam int LINE_LIMIT = 256;

    // The run is aborted after this many clock cycles.
    localparam int CYCLE_LIMIT = 100000;

    // Stop adding random phrases once the text holds this many bytes.
    localparam int TEXT_TARGET = 850;

    // The inline end marker, first character in the top byte.
    localparam logic [87:0] END_MARKER = "<<$$EOF$$>>";

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] char_code = 8'h00;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [2:0] token_kind;
    logic [7:0] start_col;
    logic [8:0] token_length;
    logic       last_of_run;

    markup_token_lexer #(
        .LINE_MAX(LINE_LIMIT)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .char_code    (char_code),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .token_kind   (token_kind),
        .start_col    (start_col),
        .token_length (token_length),
        .last_of_run  (last_of_run)
    );

    // The source text that still waits to be sent, one byte per entry.
    logic [7:0] text_bytes[$];
    int         text_total;

    // Token descriptors that the block still owes, oldest first.
    mtl_pkg::token_t expected_tokens[$];

    int         cycle_count = 0;
    int         bytes_sent = 0;
    int         tokens_checked = 0;
    int         mismatches = 0;
    int         kind_seen[8];

    // Scanner state of the prediction.
    mtl_pkg::scan_state_t lex_state;
    int          lex_col;
    int          tok_begin;
    logic        abbrev_on;
    logic        skipping;

    // Scratch of one scan step: the column of the byte, whether the line ends
    // and the descriptors that the byte has caused so far.
    int              here;
    logic            line_done;
    mtl_pkg::token_t step_out[2];
    int              step_n;

    // Between these cycles neither side ever stalls, so that the block also
    // runs for a while at its full rate.
    function automatic logic no_gaps();
        return cycle_count >= 300 && cycle_count < 900;
    endfunction

    //--------------------------------------------------------------------------
    // Character classes of the language.
    //--------------------------------------------------------------------------

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
               c == 8'hD1 || c == 8'hF1;
    endfunction

    function automatic logic is_num(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    // Characters that may follow the first character of a label.
    function automatic logic continues_label(input logic [7:0] c);
        case (c)
            "_", ".", "+", "-", "#", "/", "=", "'", "]", "|", ":": return 1'b1;
            default: return is_alpha(c) || is_num(c);
        endcase
    endfunction

    //--------------------------------------------------------------------------
    // Prediction. One call of lex_byte scans one accepted byte and appends the
    // descriptors that it causes to expected_tokens.
    //--------------------------------------------------------------------------

    // Records a descriptor of the current byte. Columns and lengths saturate at
    // the widths of the output fields.
    task automatic add_token(input mtl_pkg::token_kind_t kind, input int col,
                             input int len);
        if (step_n < 2) begin
            step_out[step_n].kind         = kind;
            step_out[step_n].start_col    = (col > 255) ? 8'd255 : col[7:0];
            step_out[step_n].token_length = (len > 511) ? 9'd511 : len[8:0];
            step_out[step_n].last_of_run  = 1'b0;
            step_n++;
        end
    endtask

    // Characters scanned so far in the current token, not counting this byte.
    function automatic int token_span();
        return (here >= tok_begin) ? here - tok_begin : 0;
    endfunction

    // Scans a byte from the start state. This is also where a byte that closed
    // the previous token is scanned a second time.
    task automatic begin_token(input logic [7:0] c);
        lex_state = mtl_pkg::S_START;
        tok_begin = here;
        if (is_alpha(c) || c == "'" || c == "[" || c == "|" || c == ":") begin
            lex_state = mtl_pkg::S_ETQ;
        end else if (is_num(c)) begin
            lex_state = mtl_pkg::S_NUM01;
        end else if (c == "(") begin
            add_token(mtl_pkg::K_OPEN, here, 1);
        end else if (c == ")") begin
            add_token(mtl_pkg::K_CLOSE, here, 1);
        end else if (c == " ") begin
            // A space ends the abbreviated form with a close of no length.
            if (abbrev_on) begin
                abbrev_on = 1'b0;
                add_token(mtl_pkg::K_CLOSE, here, 0);
            end else begin
                lex_state = mtl_pkg::S_SPC;
            end
        end else if (c == "/") begin
            lex_state = mtl_pkg::S_CMT;
        end else if (c == "+" || c == "-") begin
            lex_state = mtl_pkg::S_S01;
        end else if (c == "=") begin
            lex_state = mtl_pkg::S_S02;
        end else if (c == "\"") begin
            lex_state = mtl_pkg::S_STR;
        end else if (c == mtl_pkg::CH_EOF) begin
            add_token(mtl_pkg::K_EOF, here, 0);
        end else if (c == mtl_pkg::CH_EOL) begin
            line_done = 1'b1;
        end else if (c == "<") begin
            lex_state = mtl_pkg::S_EOF01;
        end else if (c == ",") begin
            // In the abbreviated form a bare comma only separates.
            if (!abbrev_on)
                add_token(mtl_pkg::K_ERROR, here, 1);
        end else begin
            add_token(mtl_pkg::K_ERROR, here, 1);
        end
    endtask

    // A byte that does not fit the token in progress. The byte is dropped; an
    // end of file still reports itself, anything else reports the broken text.
    task automatic reject(input logic [7:0] c);
        lex_state = mtl_pkg::S_START;
        if (c == mtl_pkg::CH_EOF) begin
            add_token(mtl_pkg::K_EOF, tok_begin, 0);
        end else begin
            add_token(mtl_pkg::K_ERROR, tok_begin, token_span() + 1);
            if (c == mtl_pkg::CH_EOL)
                line_done = 1'b1;
        end
    endtask

    task automatic lex_byte(input logic [7:0] raw);
        logic [7:0] c;
        int         idx;
        int         len;
        c         = (raw == mtl_pkg::CH_TAB) ? 8'(" ") : raw;
        here      = lex_col;
        line_done = 1'b0;
        step_n    = 0;

        if (skipping) begin
            // Inside a comment or after the end marker only the line end counts.
            if (c == mtl_pkg::CH_EOL) begin
                skipping  = 1'b0;
                line_done = 1'b1;
            end
        end else begin
            case (lex_state)
                mtl_pkg::S_START: begin_token(c);
                mtl_pkg::S_CMT: begin
                    if (c == "/") begin
                        skipping  = 1'b1;
                        lex_state = mtl_pkg::S_START;
                    end else begin
                        reject(c);
                    end
                end
                mtl_pkg::S_EOF01, mtl_pkg::S_EOF02, mtl_pkg::S_EOF03,
                mtl_pkg::S_EOF04, mtl_pkg::S_EOF05, mtl_pkg::S_EOF06,
                mtl_pkg::S_EOF07, mtl_pkg::S_EOF08, mtl_pkg::S_EOF09,
                mtl_pkg::S_EOF10: begin
                    // The first '<' of the marker was seen in the start state,
                    // so the first marker state waits for the second character.
                    idx = int'(lex_state) - int'(mtl_pkg::S_EOF01) + 1;
                    if (c != END_MARKER[87 - 8 * idx -: 8]) begin
                        reject(c);
                    end else if (lex_state == mtl_pkg::S_EOF10) begin
                        add_token(mtl_pkg::K_EOF, tok_begin, mtl_pkg::MARKER_LEN);
                        skipping  = 1'b1;
                        lex_state = mtl_pkg::S_START;
                    end else begin
                        lex_state = mtl_pkg::scan_state_t'(lex_state + 5'd1);
                    end
                end
                mtl_pkg::S_ETQ: begin
                    if (c == ",") begin
                        // The first label comma opens the abbreviated form.
                        if (!abbrev_on) begin
                            abbrev_on = 1'b1;
                            add_token(mtl_pkg::K_OPEN, tok_begin, 0);
                        end
                        add_token(mtl_pkg::K_LABEL, tok_begin, token_span());
                        lex_state = mtl_pkg::S_START;
                    end else if (!continues_label(c)) begin
                        add_token(mtl_pkg::K_LABEL, tok_begin, token_span());
                        begin_token(c);
                    end
                end
                mtl_pkg::S_NUM01: begin
                    if (c == ".") begin
                        lex_state = mtl_pkg::S_NUM02;
                    end else if (is_alpha(c)) begin
                        lex_state = mtl_pkg::S_ETQ;
                    end else if (!is_num(c)) begin
                        add_token(mtl_pkg::K_INT, tok_begin, token_span());
                        begin_token(c);
                    end
                end
                mtl_pkg::S_NUM02: begin
                    if (!is_num(c)) begin
                        add_token(mtl_pkg::K_REAL, tok_begin, token_span());
                        begin_token(c);
                    end
                end
                mtl_pkg::S_SPC: begin
                    if (c != " ")
                        begin_token(c);
                end
                mtl_pkg::S_STR: begin
                    // The quotes are not part of the reported text.
                    if (c == "\"") begin
                        len = token_span();
                        add_token(mtl_pkg::K_STRING, tok_begin + 1,
                                  (len > 0) ? len - 1 : 0);
                        lex_state = mtl_pkg::S_START;
                    end else if (c == mtl_pkg::CH_EOF || c == mtl_pkg::CH_EOL) begin
                        reject(c);
                    end
                end
                mtl_pkg::S_S01, mtl_pkg::S_S02, mtl_pkg::S_S03: begin
                    if (is_alpha(c)) begin
                        lex_state = mtl_pkg::S_ETQ;
                    end else if (is_num(c)) begin
                        lex_state = mtl_pkg::S_NUM01;
                    end else if (lex_state != mtl_pkg::S_S03 && (c == "+" || c == "-")) begin
                        lex_state = mtl_pkg::S_S03;
                    end else if (lex_state == mtl_pkg::S_S01 && c == " ") begin
                        // A lone sign before a space is a label; the space is used up.
                        add_token(mtl_pkg::K_LABEL, tok_begin, token_span());
                        lex_state = mtl_pkg::S_START;
                    end else begin
                        reject(c);
                    end
                end
                default: begin_token(c);
            endcase
        end

        if (line_done)
            lex_col = 0;
        else if (lex_col < LINE_LIMIT)
            lex_col++;

        if (step_n > 0)
            step_out[step_n - 1].last_of_run = 1'b1;
        for (int i = 0; i < step_n; i++)
            expected_tokens.push_back(step_out[i]);
    endtask

    //--------------------------------------------------------------------------
    // Text generation.
    //--------------------------------------------------------------------------

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            text_bytes.push_back(s[i]);
    endtask

    function automatic logic [7:0] pick_from(input string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    function automatic logic [7:0] random_letter();
        int r;
        r = $urandom_range(0, 53);
        if (r < 26)
            return 8'("A" + r);
        else if (r < 52)
            return 8'("a" + r - 26);
        else if (r == 52)
            return 8'hD1;
        else
            return 8'hF1;
    endfunction

    function automatic logic [7:0] random_digit();
        return 8'("0" + $urandom_range(0, 9));
    endfunction

    // Any byte that may stand inside a quoted string.
    function automatic logic [7:0] string_body_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == "\"" || c == mtl_pkg::CH_EOF || c == mtl_pkg::CH_EOL);
        return c;
    endfunction

    // Any byte that may stand inside a comment.
    function automatic logic [7:0] comment_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == mtl_pkg::CH_EOL);
        return c;
    endfunction

    task automatic queue_label();
        if ($urandom_range(0, 4) == 0)
            text_bytes.push_back(pick_from("'[|:"));
        else
            text_bytes.push_back(random_letter());
        repeat ($urandom_range(0, 5)) begin
            case ($urandom_range(0, 2))
                0: text_bytes.push_back(random_letter());
                1: text_bytes.push_back(random_digit());
                default: text_bytes.push_back(pick_from("_.+-#/=']|:"));
            endcase
        end
    endtask

    // Appends one random phrase. Most phrases are well formed tokens with
    // random content; a few are plain noise or cut-off sequences.
    task automatic queue_phrase();
        int k;
        case ($urandom_range(0, 19))
            0, 1, 2: queue_label();
            3, 4: begin
                repeat ($urandom_range(1, 4)) text_bytes.push_back(random_digit());
                case ($urandom_range(0, 3))
                    0: begin
                        text_bytes.push_back(".");
                        repeat ($urandom_range(0, 3)) text_bytes.push_back(random_digit());
                    end
                    1: text_bytes.push_back(random_letter());
                    default: ;
                endcase
            end
            5: begin
                text_bytes.push_back("\"");
                repeat ($urandom_range(0, 6)) text_bytes.push_back(string_body_byte());
                text_bytes.push_back("\"");
            end
            6, 7: text_bytes.push_back("(");
            8, 9: text_bytes.push_back(")");
            10: begin
                text_bytes.push_back(pick_from("+-="));
                case ($urandom_range(0, 4))
                    0: text_bytes.push_back(random_letter());
                    1: text_bytes.push_back(random_digit());
                    2: text_bytes.push_back(pick_from("+-"));
                    3: text_bytes.push_back(" ");
                    default: text_bytes.push_back(8'($urandom_range(0, 255)));
                endcase
            end
            11: begin
                // Abbreviated form: label commas, then usually a space to close it.
                queue_label();
                text_bytes.push_back(",");
                repeat ($urandom_range(0, 2)) begin
                    queue_label();
                    text_bytes.push_back(",");
                end
                if ($urandom_range(0, 1) == 0)
                    text_bytes.push_back(",");
                if ($urandom_range(0, 3) != 0)
                    text_bytes.push_back(" ");
            end
            12: begin
                push_text("//");
                repeat ($urandom_range(0, 4)) text_bytes.push_back(comment_byte());
                text_bytes.push_back(mtl_pkg::CH_EOL);
            end
            13: begin
                // End marker, now and then cut short by a random byte.
                k = ($urandom_range(0, 2) == 0) ? $urandom_range(1, mtl_pkg::MARKER_LEN - 1)
                                                : mtl_pkg::MARKER_LEN;
                for (int i = 0; i < k; i++)
                    text_bytes.push_back(END_MARKER[87 - 8 * i -: 8]);
                if (k < mtl_pkg::MARKER_LEN) begin
                    text_bytes.push_back(8'($urandom_range(0, 255)));
                end else begin
                    repeat ($urandom_range(0, 3)) text_bytes.push_back(comment_byte());
                    text_bytes.push_back(mtl_pkg::CH_EOL);
                end
            end
            14: text_bytes.push_back(mtl_pkg::CH_EOL);
            15: text_bytes.push_back(($urandom_range(0, 2) == 0) ? mtl_pkg::CH_EOF
                                                                 : mtl_pkg::CH_EOL);
            16: text_bytes.push_back(8'($urandom_range(0, 255)));
            default: begin
                repeat ($urandom_range(1, 3))
                    text_bytes.push_back(($urandom_range(0, 2) == 0) ? mtl_pkg::CH_TAB
                                                                     : 8'(" "));
            end
        endcase
    endtask

    //--------------------------------------------------------------------------
    // Clock, cycle counter and watchdog.
    //--------------------------------------------------------------------------

    initial begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // A run that hangs, for instance because a descriptor never arrives, ends
    // here as a failure.
    initial begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("Timeout after %0d cycles, %0d tokens still expected.",
                 cycle_count, expected_tokens.size());
        $display("CHECK FAILED");
        $finish;
    end

    //--------------------------------------------------------------------------
    // Input driver. It offers the next byte of the text whenever its slot is
    // free, idling now and then, and predicts each byte at its transfer.
    //--------------------------------------------------------------------------

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                lex_byte(char_code);
                bytes_sent++;
            end
            // The slot is free unless an offered byte is still waiting.
            if (!in_valid || in_ready) begin
                if (text_bytes.size() > 0 && (no_gaps() || $urandom_range(0, 99) >= 20)) begin
                    in_valid  <= 1'b1;
                    char_code <= text_bytes.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    //--------------------------------------------------------------------------
    // Output monitor. Every descriptor transfer is compared with the oldest
    // expected descriptor. The receiver stalls at random.
    //--------------------------------------------------------------------------

    always @(posedge clk or negedge rst_n) begin
        mtl_pkg::token_t got;
        mtl_pkg::token_t want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                got = {token_kind, start_col, token_length, last_of_run};
                if (expected_tokens.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Cycle %0d: unexpected token kind=%0d col=%0d len=%0d last=%0b",
                                 cycle_count, got.kind, got.start_col, got.token_length,
                                 got.last_of_run);
                end else begin
                    want = expected_tokens.pop_front();
                    kind_seen[want.kind]++;
                    tokens_checked++;
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"Cycle %0d: token %0d expected kind=%0d col=%0d len=%0d ",
                                      "last=%0b, got kind=%0d col=%0d len=%0d last=%0b"},
                                     cycle_count, tokens_checked, want.kind, want.start_col,
                                     want.token_length, want.last_of_run, got.kind,
                                     got.start_col, got.token_length, got.last_of_run);
                    end
                end
            end
            out_ready <= no_gaps() || $urandom_range(0, 99) >= 20;
        end
    end

    //--------------------------------------------------------------------------
    // Test sequence.
    //--------------------------------------------------------------------------

    initial begin
        logic long_line_done;

        lex_state = mtl_pkg::S_START;
        lex_col   = 0;
        tok_begin = 0;
        abbrev_on = 1'b0;
        skipping  = 1'b0;
        long_line_done = 1'b0;

        // Directed text. It walks through every token kind: an explicit open,
        // the abbreviated form with its implicit open and close, an integer, a
        // string, a lone sign before a space, a real closed by a parenthesis,
        // bad bytes at both ends of the byte range, the two extra letter codes
        // in a label ended by a line end, an end of file where it is bad, a
        // comment, a tab, a line end where it is bad, and an end of file in
        // the start state.
        push_text("(n,7 \"x\"- 9.5)");
        text_bytes.push_back(8'hFF);
        text_bytes.push_back(8'h00);
        text_bytes.push_back(8'hD1);
        text_bytes.push_back(8'hF1);
        text_bytes.push_back(mtl_pkg::CH_EOL);
        text_bytes.push_back("<");
        text_bytes.push_back(mtl_pkg::CH_EOF);
        push_text("//");
        text_bytes.push_back(mtl_pkg::CH_EOL);
        text_bytes.push_back(mtl_pkg::CH_TAB);
        text_bytes.push_back("=");
        text_bytes.push_back(mtl_pkg::CH_EOL);
        text_bytes.push_back(mtl_pkg::CH_EOF);

        // Random text. Once, a line runs well past the column limit so that the
        // column saturates, with a string on it that ends past the limit.
        while (text_bytes.size() < TEXT_TARGET) begin
            if (!long_line_done && text_bytes.size() > 400) begin
                long_line_done = 1'b1;
                text_bytes.push_back(mtl_pkg::CH_EOL);
                text_bytes.push_back("\"");
                repeat (262) text_bytes.push_back(string_body_byte());
                push_text("\"ab (");
                text_bytes.push_back(mtl_pkg::CH_EOL);
            end
            queue_phrase();
        end
        text_total = text_bytes.size();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every byte to be taken, then for every descriptor to come
        // out, then a little longer to catch anything extra.
        while (bytes_sent < text_total)
            @(posedge clk);
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Sent %0d bytes and checked %0d token descriptors in %0d cycles.",
                 bytes_sent, tokens_checked, cycle_count);
        $display({"Kinds: label %0d, open %0d, close %0d, integer %0d, real %0d, ",
                  "string %0d, end of file %0d, error %0d; mismatches %0d."},
                 kind_seen[mtl_pkg::K_LABEL], kind_seen[mtl_pkg::K_OPEN],
                 kind_seen[mtl_pkg::K_CLOSE], kind_seen[mtl_pkg::K_INT],
                 kind_seen[mtl_pkg::K_REAL], kind_seen[mtl_pkg::K_STRING],
                 kind_seen[mtl_pkg::K_EOF], kind_seen[mtl_pkg::K_ERROR], mismatches);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
